// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication across reset");

`endif

// File: hw/rtl/rsa_pkg.sv
// Shared types and constants of the running statistics accumulator.
package rsa_pkg;

    localparam int AMT_W         = 24;
    localparam int SUM_W         = 40;
    localparam int OUT_CNT_W     = 17;
    localparam int RSA_MAX_ITEMS = 65536;
    localparam int QUEUE_DEPTH   = 4;
    localparam int RES_W         = SUM_W + 3 * AMT_W + 2 * OUT_CNT_W;
    localparam int TDATA_OUT_W   = ((RES_W + 7) / 8) * 8;
    localparam int TDATA_IN_W    = ((AMT_W + 7) / 8) * 8;

    localparam logic [AMT_W-1:0] THRESH_RESET = AMT_W'(600000);
    localparam logic [AMT_W-1:0] AMT_ALL_ONES = '1;
    localparam logic [SUM_W-1:0] SUM_ALL_ONES = '1;

    // classified item passed from front to back
    typedef struct packed {
        logic [AMT_W-1:0] amount;
        logic             last;
        logic             above;
    } t_rsa_item;

    // one result of a run
    typedef struct packed {
        logic                 overflow;
        logic [OUT_CNT_W-1:0] item_count;
        logic [OUT_CNT_W-1:0] above_count;
        logic [AMT_W-1:0]     min_cents;
        logic [AMT_W-1:0]     max_cents;
        logic [AMT_W-1:0]     mean_cents;
        logic [SUM_W-1:0]     total_cents;
    } t_rsa_result;

endpackage

// File: hw/rtl/rsa_front.sv
// Front end: threshold register, input handshake and item classification.
module rsa_front
    import rsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [AMT_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [AMT_W-1:0] i_amount,
    input  logic             i_last,
    input  logic             i_q_full,
    output logic             o_push,
    output t_rsa_item        o_item
);

    logic [AMT_W-1:0] r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;

    always_comb begin
        o_item.amount = i_amount;
        o_item.last   = i_last;
        o_item.above  = (i_amount > r_threshold);
    end

endmodule

// File: hw/rtl/rsa_queue.sv
// Short item queue between front and back.
module rsa_queue
    import rsa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rsa_item i_item,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_rsa_item o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_rsa_item          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [FILL_W-1:0]  r_fill;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// File: hw/rtl/rsa_back.sv
// Back end: running statistics, mean divider and result register.
module rsa_back
    import rsa_pkg::*;
#(
    parameter int MAX_ITEMS = RSA_MAX_ITEMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_rsa_item   i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsa_result o_out
);

    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } t_div_state;

    t_div_state        r_state;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [AMT_W-1:0]  r_min, n_min;
    logic [AMT_W-1:0]  r_max, n_max;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_above, n_above;
    logic              r_ovf, n_ovf;

    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_divisor;
    logic [STEP_W-1:0] r_step;
    t_rsa_result       r_snap;
    logic              r_out_valid;
    t_rsa_result       r_out;

    logic              hit_bound;
    logic [SUM_W:0]    sum_wide;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_diff;
    logic              rem_ge;
    logic              slot_free;
    logic [AMT_W-1:0]  mean_sat;
    t_rsa_result       out_next;

    assign o_pop = i_q_valid && (!i_head.last || r_state == DIV_IDLE);

    // one item's contribution
    always_comb begin
        hit_bound = (r_cnt == CNT_W'(MAX_ITEMS));
        sum_wide  = {1'b0, r_sum} + (SUM_W + 1)'(i_head.amount);
        if (hit_bound) begin
            n_sum   = r_sum;
            n_min   = r_min;
            n_max   = r_max;
            n_cnt   = r_cnt;
            n_above = r_above;
        end else begin
            n_sum   = sum_wide[SUM_W] ? SUM_ALL_ONES : sum_wide[SUM_W-1:0];
            n_min   = (i_head.amount < r_min) ? i_head.amount : r_min;
            n_max   = (i_head.amount > r_max) ? i_head.amount : r_max;
            n_cnt   = r_cnt + 1'b1;
            n_above = r_above + CNT_W'(i_head.above);
        end
        n_ovf = r_ovf | hit_bound;
    end

    // restoring divider, one quotient bit per cycle
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_divisor};
        rem_ge   = (rem_sh >= {1'b0, r_divisor});
        mean_sat = (r_quo[SUM_W-1:AMT_W] != '0) ? AMT_ALL_ONES : r_quo[AMT_W-1:0];
        out_next            = r_snap;
        out_next.mean_cents = mean_sat;
    end

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DIV_IDLE;
            r_sum       <= '0;
            r_min       <= AMT_ALL_ONES;
            r_max       <= '0;
            r_cnt       <= '0;
            r_above     <= '0;
            r_ovf       <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_head.last) begin
                    r_sum   <= '0;
                    r_min   <= AMT_ALL_ONES;
                    r_max   <= '0;
                    r_cnt   <= '0;
                    r_above <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_sum   <= n_sum;
                    r_min   <= n_min;
                    r_max   <= n_max;
                    r_cnt   <= n_cnt;
                    r_above <= n_above;
                    r_ovf   <= n_ovf;
                end
            end

            // a reload in DIV_HOLD takes precedence over the drain
            if (r_out_valid && i_out_ready && r_state != DIV_HOLD) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                DIV_IDLE: begin
                    if (o_pop && i_head.last) begin
                        r_quo                  <= n_sum;
                        r_rem                  <= '0;
                        r_divisor              <= n_cnt;
                        r_step                 <= '0;
                        r_snap.total_cents     <= n_sum;
                        r_snap.mean_cents      <= '0;
                        r_snap.max_cents       <= n_max;
                        r_snap.min_cents       <= n_min;
                        r_snap.above_count     <= OUT_CNT_W'(n_above);
                        r_snap.item_count      <= OUT_CNT_W'(n_cnt);
                        r_snap.overflow        <= n_ovf;
                        r_state                <= DIV_RUN;
                    end
                end
                DIV_RUN: begin
                    r_rem  <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_state <= DIV_HOLD;
                    end
                end
                DIV_HOLD: begin
                    if (slot_free) begin
                        r_out       <= out_next;
                        r_out_valid <= 1'b1;
                        r_state     <= DIV_IDLE;
                    end
                end
                default: begin
                    r_state <= DIV_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/running_statistics_accumulator_unit.sv
// Top level of the running statistics accumulator.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready       | tdata: amount_cents; tlast: last
//  m_axis   | out       | m_axis_tvalid/tready       | tdata: run statistics; tuser: overflow
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_data: threshold_cents
//
// Amounts are taken one per cycle while the four-item queue has room; the
// back end retires one queued item per cycle unless a final item is held.
// A final item passes through the queue; a restoring divider then works out
// the mean, one quotient bit per cycle, and the result is loaded into the
// output register once that register is free. A further final item waits
// at the queue head until that result is loaded into the output register;
// non-final items ahead of it carry on accumulating. The result sits in an
// output register, so a stalled sink only holds back the divider once that
// register is full. Reset is synchronous, active low; the threshold returns
// to 600000.
module running_statistics_accumulator_unit
    import rsa_pkg::*;
#(
    parameter int MAX_ITEMS = RSA_MAX_ITEMS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [23:0] amount_cents
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [39:0] total_cents, [63:40] mean_cents, [87:64] max_cents,
    // [111:88] min_cents, [128:112] above_count, [145:129] item_count
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    output logic [0:0]             m_axis_tuser,   // [0] overflow
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [AMT_W-1:0]       i_cfg_data
);

    localparam int PAD_W = TDATA_OUT_W - RES_W;

    logic        q_full;
    logic        q_valid;
    logic        push;
    logic        pop;
    t_rsa_item   front_item;
    t_rsa_item   head_item;
    t_rsa_result result;

    // classify against the threshold on the way in
    rsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_amount    (s_axis_tdata[AMT_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_item      (front_item)
    );

    // decouples the front from divider stalls
    rsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head_item)
    );

    rsa_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head_item),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (result)
    );

    // pack fields lowest first, pad to whole bytes
    assign m_axis_tdata = {PAD_W'(0), result.item_count, result.above_count,
                           result.min_cents, result.max_cents, result.mean_cents,
                           result.total_cents};
    assign m_axis_tuser = result.overflow;

endmodule

// File: hw/rtl/rsa_checker.sv
// Port-level checks of the running statistics accumulator, bound to the top.
`include "assert_macros.svh"

module rsa_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [151:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // a result waiting on the sink keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // every run holds at least one amount, so extremes are ordered
    `ASSERT_IMPL(a_min_le_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[111:88] <= m_axis_tdata[87:64])

    // mean never exceeds the largest amount
    `ASSERT_IMPL(a_mean_le_max, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[63:40] <= m_axis_tdata[87:64])

    // no result straight out of reset
    `ASSERT_NEXT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind running_statistics_accumulator_unit rsa_checker u_rsa_checker (.*);

// File: sim/run_stats_checker.sv
`timescale 1ns / 100ps
// Run statistics checker: predicts each run's result from the accepted items and compares.
module run_stats_checker
    import rsa_pkg::*;
#(
    parameter int MAX_ITEMS = RSA_MAX_ITEMS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [TDATA_IN_W-1:0]  i_in_data,    // [23:0] amount_cents
    input  logic                   i_in_last,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // [39:0] total_cents, [63:40] mean_cents, [87:64] max_cents,
    // [111:88] min_cents, [128:112] above_count, [145:129] item_count
    input  logic [TDATA_OUT_W-1:0] i_out_data,
    input  logic [0:0]             i_out_user,   // [0] overflow
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [AMT_W-1:0]       i_cfg_data,
    output int unsigned            o_failures,
    output int unsigned            o_pending
);

    logic [AMT_W-1:0] threshold;
    logic [SUM_W-1:0] acc_sum;
    logic [AMT_W-1:0] acc_min;
    logic [AMT_W-1:0] acc_max;
    longint unsigned  acc_seen;
    longint unsigned  acc_above;
    logic             acc_overflow;

    logic [AMT_W-1:0] amount;
    logic [SUM_W:0]   wide_sum;
    longint unsigned  mean_full;
    logic             bad;
    t_rsa_result      want;
    t_rsa_result      got;
    t_rsa_result      stats_due[$];
    int unsigned      fail_count = 0;

    task automatic clear_run_stats();
        acc_sum      = '0;
        acc_min      = AMT_ALL_ONES;
        acc_max      = '0;
        acc_seen     = 0;
        acc_above    = 0;
        acc_overflow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            threshold = THRESH_RESET;
            clear_run_stats();
            stats_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                threshold = i_cfg_data;

            if (i_in_valid && i_in_ready) begin
                amount = i_in_data[AMT_W-1:0];
                // past the bound: item ignored, run flagged
                if (acc_seen >= MAX_ITEMS) begin
                    acc_overflow = 1'b1;
                end else begin
                    wide_sum = {1'b0, acc_sum} + amount;
                    acc_sum  = wide_sum[SUM_W] ? SUM_ALL_ONES : wide_sum[SUM_W-1:0];
                    if (amount < acc_min)
                        acc_min = amount;
                    if (amount > acc_max)
                        acc_max = amount;
                    if (amount > threshold)
                        acc_above++;
                    acc_seen++;
                end
                if (i_in_last) begin
                    mean_full = (acc_seen != 0) ? acc_sum / acc_seen : 0;
                    if (mean_full > AMT_ALL_ONES)
                        mean_full = AMT_ALL_ONES;
                    want.total_cents = acc_sum;
                    want.mean_cents  = mean_full[AMT_W-1:0];
                    want.max_cents   = acc_max;
                    want.min_cents   = acc_min;
                    want.above_count = acc_above[OUT_CNT_W-1:0];
                    want.item_count  = acc_seen[OUT_CNT_W-1:0];
                    want.overflow    = acc_overflow;
                    stats_due.push_back(want);
                    clear_run_stats();
                end
            end

            if (i_out_valid && i_out_ready) begin
                got = {i_out_user[0], i_out_data[RES_W-1:0]};
                if (stats_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with no run outstanding: total %0d items %0d",
                                 $time, got.total_cents, got.item_count);
                end else begin
                    want = stats_due.pop_front();
                    bad  = (got.total_cents !== want.total_cents)
                        || (got.mean_cents  !== want.mean_cents)
                        || (got.max_cents   !== want.max_cents)
                        || (got.min_cents   !== want.min_cents)
                        || (got.above_count !== want.above_count)
                        || (got.item_count  !== want.item_count)
                        || (got.overflow    !== want.overflow);
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: run stats exp/got: total %0d/%0d mean %0d/%0d",
                                      " max %0d/%0d min %0d/%0d above %0d/%0d",
                                      " items %0d/%0d ovf %0b/%0b"}, $time,
                                     want.total_cents, got.total_cents,
                                     want.mean_cents, got.mean_cents,
                                     want.max_cents, got.max_cents,
                                     want.min_cents, got.min_cents,
                                     want.above_count, got.above_count,
                                     want.item_count, got.item_count,
                                     want.overflow, got.overflow);
                    end
                end
            end
        end
        o_failures <= fail_count;
        o_pending  <= stats_due.size();
    end

endmodule

// File: sim/tb_running_statistics_accumulator_unit.sv
`timescale 1ns / 100ps
// Testbench top for the running statistics accumulator: stimulus, idling control and verdict.
module tb_running_statistics_accumulator_unit;
    import rsa_pkg::*;

    localparam int               BOUND             = RSA_MAX_ITEMS;
    localparam int unsigned      IDLE_LIMIT        = 5000;   // cycles with no handshake at all
    localparam int unsigned      SETTLE_CYCLES     = 64;     // divider plus queue, with margin
    localparam int unsigned      SINK_HOLD_CYCLES  = 400;
    localparam logic [AMT_W-1:0] AMT_TOP           = AMT_W'(10000000);

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;    // [23:0] amount_cents
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic [AMT_W-1:0]       i_cfg_data    = '0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire [TDATA_OUT_W-1:0]  m_axis_tdata;          // run statistics, total_cents lowest
    wire [0:0]              m_axis_tuser;          // [0] overflow
    wire                    o_cfg_ready;

    int unsigned            failures;
    int unsigned            pending;

    // idling controls: sender percentage read by the stimulus only,
    // sink percentage and hold-off read by the sink process
    int unsigned            src_idle_pct   = 0;
    int unsigned            sink_stall_pct = 0;
    logic                   sink_hold      = 1'b0;
    logic                   hold_go        = 1'b0;
    logic [AMT_W-1:0]       cur_threshold  = THRESH_RESET;
    int unsigned            idle_cycles    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    running_statistics_accumulator_unit #(
        .MAX_ITEMS (BOUND)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    run_stats_checker #(
        .MAX_ITEMS (BOUND)
    ) u_stats_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // result sink: random stalls, or held off entirely during the pressure test
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // long sink hold-off, timed here so the sender keeps offering items meanwhile
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // watchdog: gives up after a long stretch with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("running_statistics_accumulator_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // offer one amount, with random idle cycles in front; returns on acceptance
    task automatic send_item(input logic [AMT_W-1:0] amt, input logic lst);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_IN_W'(amt);
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // threshold writes only with the block idle: drained, then the divider's time
    task automatic set_threshold(input logic [AMT_W-1:0] value);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_threshold = value;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
    endtask

    // mostly in-range amounts, with the threshold edges, the range ends
    // and full 24-bit values mixed in
    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(9))
            0:       return AMT_W'($urandom);
            1:       return AMT_W'(cur_threshold + $urandom_range(2) - 1);
            2:       return ($urandom_range(1) != 0) ? AMT_TOP : '0;
            default: return AMT_W'($urandom_range(AMT_TOP));
        endcase
    endfunction

    // whole runs only, mostly short, now and then up to max_len + 1 items
    task automatic send_runs(input int unsigned n_items, input int unsigned max_len);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(max_len) + 1;
            else
                len = $urandom_range(3) + 1;
            for (int unsigned k = 1; k <= len; k++)
                send_item(pick_amount(), k == len);
            sent += len;
            if ($urandom_range(24) == 0)
                wait_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset threshold, no idling
        send_item('0, 1'b1);                        // one-item run, smallest amount
        send_item(AMT_ALL_ONES, 1'b1);              // one-item run, beyond the stated range
        send_item(THRESH_RESET, 1'b0);              // equal to threshold: not counted
        send_item(THRESH_RESET + 1'b1, 1'b0);
        send_item(THRESH_RESET - 1'b1, 1'b0);
        send_item(AMT_TOP, 1'b1);
        send_item(AMT_W'(1), 1'b0);                 // mean 3 / 2 truncates
        send_item(AMT_W'(2), 1'b1);
        send_item(AMT_W'(5), 1'b0);
        send_item(AMT_ALL_ONES, 1'b0);
        send_item('0, 1'b1);
        set_threshold('0);
        send_item('0, 1'b0);
        send_item(AMT_W'(1), 1'b1);
        set_threshold(AMT_ALL_ONES);                // nothing can be above
        send_item(AMT_ALL_ONES, 1'b0);
        send_item(AMT_W'(7), 1'b1);
        set_threshold(AMT_TOP);
        send_item(AMT_TOP, 1'b0);
        send_item(AMT_TOP + 1'b1, 1'b1);

        // random phases
        set_threshold(AMT_W'($urandom_range(AMT_TOP)));
        set_idling(0, 0);
        send_runs(250, 12);

        set_threshold('0);
        set_idling(79, 0);
        send_runs(250, 12);

        set_threshold(AMT_ALL_ONES);
        set_idling(0, 79);
        send_runs(250, 12);

        set_threshold(AMT_TOP);
        set_idling(10, 10);
        send_runs(250, 12);

        // pressure: sink held off while short runs keep coming, so the queue
        // fills and the input stalls
        set_threshold(AMT_W'($urandom_range(AMT_TOP)));
        set_idling(0, 0);
        hold_go = 1'b1;
        send_runs(250, 2);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("running_statistics_accumulator_unit: match");
        else
            $display("running_statistics_accumulator_unit: mismatch");
        $finish;
    end

endmodule
